/* rtl/matrix4_transform_chain_macros.svh */
// assertion macros shared by the rtl
`ifndef MATRIX4_TRANSFORM_CHAIN_MACROS_SVH
`define MATRIX4_TRANSFORM_CHAIN_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define M4TC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define M4TC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define M4TC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define M4TC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/m4tc_pkg.sv */
package m4tc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int ELEMS     = 16;
   localparam int DIM       = 4;
   localparam int IDX_W     = $clog2(ELEMS);
   localparam int MUL_STEPS = ELEMS;
   localparam int CNT_W     = $clog2(MUL_STEPS);
   // shifted product and four-term sum widths
   localparam int PROD_W    = 2 * DATA_W - FRAC_BITS;
   localparam int SUM_W     = PROD_W + 2;

   localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(64'd1 << FRAC_BITS);

   typedef enum logic [2:0] {
      ACT_WR_CUR = 3'd0,
      ACT_WR_OP  = 3'd1,
      ACT_MUL    = 3'd2,
      ACT_TRANS  = 3'd3,
      ACT_SCALE  = 3'd4,
      ACT_READ   = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FLUSH,
      ST_COMMIT,
      ST_SCALE_WB
   } state_type;

   typedef struct packed {
      logic wr_cur;
      logic wr_op;
      logic trans;
      logic scale_mul;
      logic scale_wb;
      logic rd;
      logic mul_step;
      logic rot_row;
      logic sum_shift;
      logic commit;
   } cmd_type;

   // clamp a wide signed value to the 32-bit range
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic in_range;
      in_range = (v[SUM_W-1:DATA_W-1] == '0) || (v[SUM_W-1:DATA_W-1] == '1);
      if (in_range) begin
         return v[DATA_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

endpackage

/* rtl/matrix4_transform_chain.sv */
// channel | dir | payload                                        | handshake
// req     | in  | tuser: action; tdata: index, value, x, y, z    | req_tvalid / req_tready
// rsp     | out | tdata: read_index, read_value                  | rsp_tvalid / rsp_tready
//
// write, translate and read beats need only the accepting cycle; scale adds a write-back state
// multiply runs from the accepting cycle through 16 steps on four shared 32x32
//   multiplier lanes, ST_FLUSH to drain the adder stage and ST_COMMIT to copy the result
// synchronous active-high reset loads both matrices with the identity
// any beat is taken only while the output register is free or being emptied
// no beat is taken while a multiply or scale is still in flight

`include "matrix4_transform_chain_macros.svh"

module matrix4_transform_chain (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [2:0]   req_tuser,   // action
   input  logic [135:0] req_tdata,   // elem_index, elem_value, x_amount, y_amount, z_amount
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata    // read_index, read_value
);
   import m4tc_pkg::*;

   cmd_type                  cmd;
   state_type                state;
   logic [IDX_W-1:0]         read_index;
   logic signed [DATA_W-1:0] read_value;

   // controller: sequencing and handshake
   m4tc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .req_tready (req_tready),
      .cmd        (cmd),
      .state      (state)
   );

   // datapath: matrices, multiplier lanes, adder tree and output register
   m4tc_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .elem_index (req_tdata[3:0]),
      .elem_value (req_tdata[35:4]),
      .x_amount   (req_tdata[67:36]),
      .y_amount   (req_tdata[99:68]),
      .z_amount   (req_tdata[131:100]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .read_index (read_index),
      .read_value (read_value)
   );

   assign rsp_tdata = {4'b0, read_value, read_index};

   // multiply keeps the input closed on the following cycle
   `M4TC_ASSERT_NXT(a_mul_busy, clock, reset, req_tvalid && req_tready && req_tuser == ACT_MUL, !req_tready && state == ST_MUL, "multiply did not block input")
   // a read is only taken when the output register can take it
   `M4TC_ASSERT_IMP(a_rd_room, clock, reset, req_tvalid && req_tready && req_tuser == ACT_READ, !rsp_tvalid || rsp_tready, "read accepted over a held result")
   // a result appears only after a read beat
   `M4TC_ASSERT_IMP(a_rsp_src, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready && req_tuser == ACT_READ), "result without read")
   // commit only happens with the input closed
   `M4TC_ASSERT_IMP(a_commit_idle, clock, reset, cmd.commit, !req_tready && !cmd.sum_shift, "commit overlaps other work")

endmodule

/* rtl/m4tc_ctrl.sv */
module m4tc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic [2:0]             req_action,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic                   req_tready,
   output m4tc_pkg::cmd_type      cmd,
   output m4tc_pkg::state_type    state
);
   import m4tc_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !rsp_tvalid || rsp_tready;
            if (req_tvalid && req_tready) begin
               unique case (req_action)
                  ACT_WR_CUR: cmd.wr_cur = 1'b1;
                  ACT_WR_OP:  cmd.wr_op  = 1'b1;
                  ACT_MUL: begin
                     cnt_in   = '0;
                     state_in = ST_MUL;
                  end
                  ACT_TRANS:  cmd.trans = 1'b1;
                  ACT_SCALE: begin
                     cmd.scale_mul = 1'b1;
                     state_in      = ST_SCALE_WB;
                  end
                  ACT_READ:   cmd.rd = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            cmd.mul_step  = 1'b1;
            cmd.rot_row   = (cnt_ff[1:0] == 2'(DIM - 1));
            cmd.sum_shift = (cnt_ff != '0);
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            cmd.sum_shift = 1'b1;
            state_in      = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_SCALE_WB: begin
            cmd.scale_wb = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign state = state_ff;

endmodule

/* rtl/m4tc_dpath.sv */
module m4tc_dpath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  m4tc_pkg::cmd_type                       cmd,
   input  logic [m4tc_pkg::IDX_W-1:0]              elem_index,
   input  logic signed [m4tc_pkg::DATA_W-1:0]      elem_value,
   input  logic signed [m4tc_pkg::DATA_W-1:0]      x_amount,
   input  logic signed [m4tc_pkg::DATA_W-1:0]      y_amount,
   input  logic signed [m4tc_pkg::DATA_W-1:0]      z_amount,
   input  logic                                    rsp_tready,
   output logic                                    rsp_tvalid,
   output logic [m4tc_pkg::IDX_W-1:0]              read_index,
   output logic signed [m4tc_pkg::DATA_W-1:0]      read_value
);
   import m4tc_pkg::*;

   logic signed [DATA_W-1:0] cur_ff [ELEMS];
   logic signed [DATA_W-1:0] cur_in [ELEMS];
   logic signed [DATA_W-1:0] op_ff  [ELEMS];
   logic signed [DATA_W-1:0] op_in  [ELEMS];
   logic signed [DATA_W-1:0] acc_ff [ELEMS];
   logic signed [PROD_W-1:0] prod_ff [DIM];
   logic signed [PROD_W-1:0] prod_in [DIM];
   logic signed [DATA_W-1:0] mul_a [DIM];
   logic signed [DATA_W-1:0] mul_b [DIM];
   logic signed [2*DATA_W-1:0] full [DIM];
   logic signed [SUM_W-1:0]  dot_sum;
   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_idx_ff;
   logic signed [DATA_W-1:0] rsp_val_ff;

   // four shared multiplier lanes: row 0 of cur times column 0 of op, or the scale diagonal
   always_comb begin
      for (int k = 0; k < DIM; k++) begin
         mul_a[k] = cur_ff[k*DIM];
         mul_b[k] = op_ff[k];
      end
      if (cmd.scale_mul) begin
         mul_a[0] = cur_ff[0];
         mul_b[0] = x_amount;
         mul_a[1] = cur_ff[5];
         mul_b[1] = y_amount;
         mul_a[2] = cur_ff[10];
         mul_b[2] = z_amount;
         mul_a[3] = '0;
         mul_b[3] = '0;
      end
      for (int k = 0; k < DIM; k++) begin
         full[k]    = mul_a[k] * mul_b[k];
         // arithmetic shift floors toward minus infinity
         prod_in[k] = PROD_W'(full[k] >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIM; k++) begin
         prod_ff[k] <= prod_in[k];
      end
   end

   assign dot_sum = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1])
                  + SUM_W'(prod_ff[2]) + SUM_W'(prod_ff[3]);

   // result shift line, newest element at position 0
   always_ff @(posedge clock) begin
      if (cmd.sum_shift) begin
         acc_ff[0] <= sat32(dot_sum);
         for (int i = 1; i < ELEMS; i++) begin
            acc_ff[i] <= acc_ff[i-1];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < ELEMS; i++) begin
         cur_in[i] = cur_ff[i];
         op_in[i]  = op_ff[i];
      end
      if (cmd.wr_cur) begin
         cur_in[elem_index] = elem_value;
      end
      if (cmd.wr_op) begin
         op_in[elem_index] = elem_value;
      end
      if (cmd.trans) begin
         cur_in[12] = sat32(SUM_W'(cur_ff[12]) + SUM_W'(x_amount));
         cur_in[13] = sat32(SUM_W'(cur_ff[13]) + SUM_W'(y_amount));
         cur_in[14] = sat32(SUM_W'(cur_ff[14]) + SUM_W'(z_amount));
      end
      if (cmd.scale_wb) begin
         cur_in[0]  = sat32(SUM_W'(prod_ff[0]));
         cur_in[5]  = sat32(SUM_W'(prod_ff[1]));
         cur_in[10] = sat32(SUM_W'(prod_ff[2]));
      end
      if (cmd.mul_step) begin
         // next column of op moves to the lane inputs
         for (int i = 0; i < ELEMS; i++) begin
            op_in[i] = op_ff[(i + DIM) % ELEMS];
         end
      end
      if (cmd.rot_row) begin
         // next row of cur moves to row 0
         for (int c = 0; c < DIM; c++) begin
            for (int r = 0; r < DIM; r++) begin
               cur_in[c*DIM + r] = cur_ff[c*DIM + (r + 1) % DIM];
            end
         end
      end
      if (cmd.commit) begin
         // element (c, r) was produced at step r*4 + c
         for (int c = 0; c < DIM; c++) begin
            for (int r = 0; r < DIM; r++) begin
               cur_in[c*DIM + r] = acc_ff[ELEMS - 1 - (r*DIM + c)];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ELEMS; i++) begin
            cur_ff[i] <= ((i % (DIM + 1)) == 0) ? FX_ONE : '0;
            op_ff[i]  <= ((i % (DIM + 1)) == 0) ? FX_ONE : '0;
         end
      end else begin
         for (int i = 0; i < ELEMS; i++) begin
            cur_ff[i] <= cur_in[i];
            op_ff[i]  <= op_in[i];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rd) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rsp_idx_ff <= elem_index;
         rsp_val_ff <= cur_ff[elem_index];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign read_index = rsp_idx_ff;
   assign read_value = rsp_val_ff;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

import m4tc_pkg::*;

// one expected read beat: element position and its Q16.16 value
typedef struct packed {
   logic [IDX_W-1:0]  index;
   logic [DATA_W-1:0] value;
} read_beat_type;

// shadow copy of both matrices; predicts every read beat from the accepted stream
class matrix_shadow;
   logic signed [DATA_W-1:0] cur_mat  [ELEMS];
   logic signed [DATA_W-1:0] opnd_mat [ELEMS];
   read_beat_type            reads_due [$];
   int                       mismatches;

   function new();
      for (int i = 0; i < ELEMS; i++) begin
         cur_mat[i]  = (i % 5 == 0) ? FX_ONE : '0;
         opnd_mat[i] = (i % 5 == 0) ? FX_ONE : '0;
      end
      mismatches = 0;
   endfunction

   // full 64-bit product, arithmetic shift gives floor
   function longint fx_product(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> FRAC_BITS;
   endfunction

   function logic signed [DATA_W-1:0] clamp32(longint v);
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         return 32'h7FFF_FFFF;
      end else if (v < 64'shFFFF_FFFF_8000_0000) begin
         return 32'h8000_0000;
      end
      return v[DATA_W-1:0];
   endfunction

   function void note_beat(logic [2:0] act, logic [IDX_W-1:0] idx,
                           logic signed [DATA_W-1:0] val, logic signed [DATA_W-1:0] x,
                           logic signed [DATA_W-1:0] y, logic signed [DATA_W-1:0] z);
      logic signed [DATA_W-1:0] prod [ELEMS];
      longint                   acc;
      read_beat_type            beat;
      case (act)
         ACT_WR_CUR: cur_mat[idx] = val;
         ACT_WR_OP:  opnd_mat[idx] = val;
         ACT_MUL: begin
            for (int c = 0; c < DIM; c++) begin
               for (int r = 0; r < DIM; r++) begin
                  acc = 0;
                  for (int k = 0; k < DIM; k++) begin
                     acc += fx_product(cur_mat[k*DIM + r], opnd_mat[c*DIM + k]);
                  end
                  prod[c*DIM + r] = clamp32(acc);
               end
            end
            cur_mat = prod;
         end
         ACT_TRANS: begin
            cur_mat[12] = clamp32(longint'(cur_mat[12]) + longint'(x));
            cur_mat[13] = clamp32(longint'(cur_mat[13]) + longint'(y));
            cur_mat[14] = clamp32(longint'(cur_mat[14]) + longint'(z));
         end
         ACT_SCALE: begin
            cur_mat[0]  = clamp32(fx_product(cur_mat[0], x));
            cur_mat[5]  = clamp32(fx_product(cur_mat[5], y));
            cur_mat[10] = clamp32(fx_product(cur_mat[10], z));
         end
         ACT_READ: begin
            beat.index = idx;
            beat.value = cur_mat[idx];
            reads_due.push_back(beat);
         end
         default: ;
      endcase
   endfunction

   function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s", msg);
      end
   endfunction

   function void check_read(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      read_beat_type due;
      if (reads_due.size() == 0) begin
         flag($sformatf("unexpected read beat: index %0d value %08h", idx, value));
         return;
      end
      due = reads_due.pop_front();
      if (idx !== due.index) begin
         flag($sformatf("read_index: expected %0d, got %0d", due.index, idx));
      end
      if (value !== due.value) begin
         flag($sformatf("read_value at %0d: expected %08h, got %08h",
                        due.index, due.value, value));
      end
   endfunction
endclass

module testbench;

   // action codes the block has no use for; they must leave everything unchanged
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;
   localparam int         CYCLE_LIMIT = 200000;
   // multiply is the longest operation
   localparam int         DRAIN_CYCLES = 40;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [2:0]   req_tuser = '0;   // action
   logic [135:0] req_tdata = '0;   // elem_index, elem_value, x_amount, y_amount, z_amount
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;        // read_index, read_value

   int           send_idle_pct = 0;
   int           take_stall_pct = 0;
   int           cycle_count = 0;
   matrix_shadow shadow;

   matrix4_transform_chain dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // read beat sink: check what was taken at this edge, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         shadow.check_read(rsp_tdata[3:0], rsp_tdata[35:4]);
      end
      rsp_tready <= !reset && ($urandom_range(99) >= take_stall_pct);
   end

   // present one beat, holding it until taken; idle cycles only before valid goes up
   task automatic send_beat(input logic [2:0] act, input logic [3:0] idx,
                            input logic [31:0] val, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {4'b0, z, y, x, val, idx};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      shadow.note_beat(act, idx, val, x, y, z);
   endtask

   // mostly small Q16.16 values so products stay meaningful, plus full range and extremes
   function automatic logic [31:0] rand_fixed();
      case ($urandom_range(5))
         0: return $urandom;
         1: return ($urandom_range(1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
      endcase
   endfunction

   task automatic random_beat();
      int          pick;
      logic [2:0]  act;
      pick = $urandom_range(99);
      if (pick < 20) begin
         act = ACT_WR_CUR;
      end else if (pick < 40) begin
         act = ACT_WR_OP;
      end else if (pick < 50) begin
         act = ACT_MUL;
      end else if (pick < 60) begin
         act = ACT_TRANS;
      end else if (pick < 70) begin
         act = ACT_SCALE;
      end else if (pick < 97) begin
         act = ACT_READ;
      end else begin
         act = ($urandom_range(1) == 1) ? ACT_SPARE_7 : ACT_SPARE_6;
      end
      send_beat(act, 4'($urandom_range(15)), rand_fixed(), rand_fixed(), rand_fixed(),
                rand_fixed());
   endtask

   initial begin
      shadow = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // sender light, receiver heavy
      send_idle_pct  = 11;
      take_stall_pct = 57;

      // identity after reset, corners of the index
      send_beat(ACT_READ, 4'd0, '0, '0, '0, '0);
      send_beat(ACT_READ, 4'd15, '1, '1, '1, '1);
      // spare action codes carrying all-ones or extreme fields must do nothing
      send_beat(ACT_SPARE_6, 4'd15, '1, '1, '1, '1);
      send_beat(ACT_SPARE_7, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '1);
      send_beat(ACT_READ, 4'd5, '0, '0, '0, '0);
      // extreme elements, then a multiply that saturates one element at the positive rail
      send_beat(ACT_WR_CUR, 4'd0, 32'h7FFF_FFFF, '0, '0, '0);
      send_beat(ACT_WR_CUR, 4'd5, 32'h8000_0000, '1, '1, '1);
      send_beat(ACT_WR_OP, 4'd0, 32'h0002_0000, '0, '0, '0);
      send_beat(ACT_WR_OP, 4'd15, 32'hFFFF_8000, '0, '0, '0);
      send_beat(ACT_MUL, 4'd0, '1, '1, '1, '1);
      send_beat(ACT_READ, 4'd0, '0, '0, '0, '0);
      send_beat(ACT_READ, 4'd5, '0, '0, '0, '0);
      send_beat(ACT_READ, 4'd15, '0, '0, '0, '0);
      // translate overflow on both rails
      send_beat(ACT_TRANS, 4'd3, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send_beat(ACT_TRANS, 4'd3, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_beat(ACT_READ, 4'd12, '0, '0, '0, '0);
      send_beat(ACT_READ, 4'd13, '0, '0, '0, '0);
      send_beat(ACT_READ, 4'd14, '0, '0, '0, '0);
      // scale rounding toward minus infinity on a tiny element
      send_beat(ACT_WR_CUR, 4'd10, 32'h0000_0001, '0, '0, '0);
      send_beat(ACT_SCALE, 4'd0, '0, 32'h0000_8000, 32'hFFFF_0000, 32'hFFFF_FFFF);
      send_beat(ACT_READ, 4'd0, '0, '0, '0, '0);
      send_beat(ACT_READ, 4'd5, '0, '0, '0, '0);
      send_beat(ACT_READ, 4'd10, '0, '0, '0, '0);

      repeat (170) random_beat();

      // sender heavy, receiver light
      send_idle_pct  = 57;
      take_stall_pct = 11;
      repeat (185) random_beat();

      // back to back on both sides
      send_idle_pct  = 0;
      take_stall_pct = 0;
      repeat (185) random_beat();

      req_tvalid <= 1'b0;
      while (shadow.reads_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (shadow.mismatches == 0 && shadow.reads_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
